/* src/hill_cipher_2x2_codec_core_assert.svh */
// Assertion macros used by the checker file of the Hill cipher codec.
`ifndef HILL_CIPHER_2X2_CODEC_CORE_ASSERT_SVH
`define HILL_CIPHER_2X2_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define HC2_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hc2 assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define HC2_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hc2 assertion failed");

`endif

/* src/hc2_pkg.sv */
// Shared constants, command/status types and mod-26 helper functions of the Hill codec.
package hc2_pkg;

   localparam int unsigned CharW    = 7;
   localparam int unsigned ValW     = 5;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned OpW      = 3;
   localparam int unsigned SelW     = 2;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 5;
   localparam int unsigned ProdW    = 2 * ValW;
   localparam int unsigned SumW     = ProdW + 1;
   localparam int unsigned RecipW   = 12;
   localparam int unsigned ScaledW  = SumW + RecipW;
   localparam int unsigned RecipShift = 16;
   localparam int unsigned QuotW    = 6;
   localparam int unsigned MapSteps = 5;

   localparam logic [ValW-1:0]   Modulus    = 5'd26;
   localparam logic [ValW-1:0]   PadValue   = 5'd23;
   localparam logic [RecipW-1:0] RecipMul   = 12'd2521;
   localparam logic [CharW-1:0]  LetterBase = 7'd65;
   localparam logic [CharW-1:0]  LowerA     = 7'd97;
   localparam logic [CharW-1:0]  LowerZ     = 7'd122;
   localparam logic [CharW-1:0]  CaseOffset = 7'd32;
   localparam logic [CharW:0]    MapOffset  = 8'd13;

   // register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] RegKeyA = 3'd0;
   localparam logic [CsrIdxW-1:0] RegKeyB = 3'd1;
   localparam logic [CsrIdxW-1:0] RegKeyC = 3'd2;
   localparam logic [CsrIdxW-1:0] RegKeyD = 3'd3;
   localparam logic [CsrIdxW-1:0] RegMode = 3'd4;

   // dot-product operand sets
   localparam logic [OpW-1:0] OpDet   = 3'd0;
   localparam logic [OpW-1:0] OpInvLo = 3'd1;
   localparam logic [OpW-1:0] OpInvHi = 3'd2;
   localparam logic [OpW-1:0] OpPair  = 3'd3;
   localparam logic [OpW-1:0] OpPad   = 3'd4;

   // result sources
   localparam logic [SelW-1:0] SelRow1   = 2'd0;
   localparam logic [SelW-1:0] SelRow2   = 2'd1;
   localparam logic [SelW-1:0] SelErrKey = 2'd2;
   localparam logic [SelW-1:0] SelErrLen = 2'd3;

   localparam logic [StatusW-1:0] StatusOk  = 2'd0;
   localparam logic [StatusW-1:0] StatusKey = 2'd1;
   localparam logic [StatusW-1:0] StatusLen = 2'd2;

   typedef struct packed {
      logic            accept;
      logic            hold;
      logic            dot_go;
      logic [OpW-1:0]  dot_op;
      logic            wr_det;
      logic            wr_ik_lo;
      logic            wr_ik_hi;
      logic            out_load;
      logic [SelW-1:0] out_sel;
      logic            out_last;
   } hc2_cmd_type;

   typedef struct packed {
      logic decrypt;
      logic inv_ok;
      logic dot_done;
      logic out_free;
   } hc2_sts_type;

   function automatic logic [ValW-1:0] mod26_key(input logic [ValW-1:0] k);
      return (k >= Modulus) ? ValW'(k - Modulus) : k;
   endfunction

   function automatic logic [ValW-1:0] neg26(input logic [ValW-1:0] x);
      return (x == '0) ? '0 : ValW'(Modulus - x);
   endfunction

   // (code - 65) mod 26, with optional lowercase fold
   function automatic logic [ValW-1:0] map_char(input logic [CharW-1:0] code,
                                                input logic fold);
      logic [CharW-1:0] c;
      logic [CharW:0]   x;
      c = code;
      if (fold && code >= LowerA && code <= LowerZ) c = CharW'(code - CaseOffset);
      x = {1'b0, c} + MapOffset;
      for (int i = 0; i < MapSteps; i++) begin
         if (x >= (CharW+1)'(Modulus)) x = x - (CharW+1)'(Modulus);
      end
      return x[ValW-1:0];
   endfunction

   // multiplicative inverse mod 26, zero when none exists
   function automatic logic [ValW-1:0] inv26(input logic [ValW-1:0] det);
      logic [ValW-1:0] r;
      unique case (det)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

/* src/hill_cipher_2x2_codec_core.sv */
// A character that closes a pair runs through the dot-product pipeline and is shown as two
// letters, first then second, or as one error result; a character that only opens a pair is held.
// The first character of each message first makes three passes through the
// 3-stage mod-26 dot-product pipeline to build the determinant and the inverse key.
// A new character is accepted only after the last one is done, as that single pipeline is shared.
// Reset (synchronous): keys to identity, encrypt mode, no message open, result empty.
module hill_cipher_2x2_codec_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hc2_pkg::CharW-1:0]    req_char_code,
   input  logic                         req_last_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hc2_pkg::CharW-1:0]    rsp_out_letter,
   output logic [hc2_pkg::StatusW-1:0]  rsp_status,
   output logic                         rsp_last_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hc2_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hc2_pkg::CsrDataW-1:0] csr_wdata
);

   hc2_pkg::hc2_cmd_type cmd;
   hc2_pkg::hc2_sts_type sts;

   assign csr_ready = 1'b1;

   hc2_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last_in (req_last_in),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   hc2_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_char_code  (req_char_code),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_letter (rsp_out_letter),
      .rsp_status     (rsp_status),
      .rsp_last_out   (rsp_last_out),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

/* src/hc2_ctrl.sv */
// Sequencer of the Hill codec: message start, pairing, result ordering.
module hc2_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_in,
   output logic                req_stall,
   input  hc2_pkg::hc2_sts_type sts,
   output hc2_pkg::hc2_cmd_type cmd
);

   localparam logic [3:0] StIdle      = 4'd0;
   localparam logic [3:0] StDet       = 4'd1;
   localparam logic [3:0] StDetWait   = 4'd2;
   localparam logic [3:0] StInvLo     = 4'd3;
   localparam logic [3:0] StInvLoWait = 4'd4;
   localparam logic [3:0] StInvHi     = 4'd5;
   localparam logic [3:0] StInvHiWait = 4'd6;
   localparam logic [3:0] StDecide    = 4'd7;
   localparam logic [3:0] StPairWait  = 4'd8;
   localparam logic [3:0] StOut1      = 4'd9;
   localparam logic [3:0] StOut2      = 4'd10;
   localparam logic [3:0] StErr       = 4'd11;

   logic [3:0]                state_ff, state_in;
   logic                      in_msg_ff, in_msg_in;
   logic                      held_vld_ff, held_vld_in;
   logic                      msg_last_ff, msg_last_in;
   logic [hc2_pkg::SelW-1:0]  err_sel_ff, err_sel_in;

   always_comb begin
      state_in    = state_ff;
      in_msg_in   = in_msg_ff;
      held_vld_in = held_vld_ff;
      msg_last_in = msg_last_ff;
      err_sel_in  = err_sel_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         StIdle: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept  = 1'b1;
               msg_last_in = req_last_in;
               if (!in_msg_ff) begin
                  in_msg_in = 1'b1;
                  state_in  = StDet;
               end else begin
                  state_in = StDecide;
               end
            end
         end
         StDet: begin
            cmd.dot_go = 1'b1;
            cmd.dot_op = hc2_pkg::OpDet;
            state_in   = StDetWait;
         end
         StDetWait: begin
            if (sts.dot_done) begin
               cmd.wr_det = 1'b1;
               state_in   = StInvLo;
            end
         end
         StInvLo: begin
            cmd.dot_go = 1'b1;
            cmd.dot_op = hc2_pkg::OpInvLo;
            state_in   = StInvLoWait;
         end
         StInvLoWait: begin
            if (sts.dot_done) begin
               cmd.wr_ik_lo = 1'b1;
               state_in     = StInvHi;
            end
         end
         StInvHi: begin
            cmd.dot_go = 1'b1;
            cmd.dot_op = hc2_pkg::OpInvHi;
            state_in   = StInvHiWait;
         end
         StInvHiWait: begin
            if (sts.dot_done) begin
               cmd.wr_ik_hi = 1'b1;
               state_in     = StDecide;
            end
         end
         StDecide: begin
            if (msg_last_ff) in_msg_in = 1'b0;
            if (held_vld_ff) begin
               held_vld_in = 1'b0;
               if (sts.decrypt && !sts.inv_ok) begin
                  err_sel_in = hc2_pkg::SelErrKey;
                  state_in   = StErr;
               end else begin
                  cmd.dot_go = 1'b1;
                  cmd.dot_op = hc2_pkg::OpPair;
                  state_in   = StPairWait;
               end
            end else if (msg_last_ff) begin
               // odd final character: error in decrypt, pad with X in encrypt
               if (sts.decrypt) begin
                  err_sel_in = hc2_pkg::SelErrLen;
                  state_in   = StErr;
               end else begin
                  cmd.dot_go = 1'b1;
                  cmd.dot_op = hc2_pkg::OpPad;
                  state_in   = StPairWait;
               end
            end else begin
               cmd.hold    = 1'b1;
               held_vld_in = 1'b1;
               state_in    = StIdle;
            end
         end
         StPairWait: begin
            if (sts.dot_done) state_in = StOut1;
         end
         StOut1: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = hc2_pkg::SelRow1;
               state_in     = StOut2;
            end
         end
         StOut2: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = hc2_pkg::SelRow2;
               cmd.out_last = msg_last_ff;
               state_in     = StIdle;
            end
         end
         StErr: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = err_sel_ff;
               cmd.out_last = msg_last_ff;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         in_msg_ff   <= 1'b0;
         held_vld_ff <= 1'b0;
         msg_last_ff <= 1'b0;
         err_sel_ff  <= hc2_pkg::SelErrKey;
      end else begin
         state_ff    <= state_in;
         in_msg_ff   <= in_msg_in;
         held_vld_ff <= held_vld_in;
         msg_last_ff <= msg_last_in;
         err_sel_ff  <= err_sel_in;
      end
   end

endmodule

/* src/hc2_dot.sv */
// Three-stage pipeline for two mod-26 dot products of a 2x2 matrix and a vector.
module hc2_dot (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [hc2_pkg::ValW-1:0] m0,
   input  logic [hc2_pkg::ValW-1:0] m1,
   input  logic [hc2_pkg::ValW-1:0] m2,
   input  logic [hc2_pkg::ValW-1:0] m3,
   input  logic [hc2_pkg::ValW-1:0] p1,
   input  logic [hc2_pkg::ValW-1:0] p2,
   output logic                     done,
   output logic [hc2_pkg::ValW-1:0] r1,
   output logic [hc2_pkg::ValW-1:0] r2
);

   localparam int unsigned PW = hc2_pkg::ProdW;
   localparam int unsigned SW = hc2_pkg::SumW;
   localparam int unsigned XW = hc2_pkg::ScaledW;
   localparam int unsigned QW = hc2_pkg::QuotW;
   localparam int unsigned VW = hc2_pkg::ValW;

   logic [2:0]    vld_ff, vld_in;
   logic [PW-1:0] prod0_ff, prod1_ff, prod2_ff, prod3_ff;
   logic [SW-1:0] sum1_ff, sum2_ff, sum1_in, sum2_in;
   logic [XW-1:0] scaled1, scaled2;
   logic [QW-1:0] quo1_ff, quo2_ff;
   logic [SW-1:0] rem1_in, rem2_in;
   logic [VW-1:0] r1_ff, r2_ff;

   assign vld_in  = {vld_ff[1:0], go};
   assign sum1_in = SW'(prod0_ff) + SW'(prod1_ff);
   assign sum2_in = SW'(prod2_ff) + SW'(prod3_ff);
   // quotient by reciprocal: exact for sums up to 1250
   assign scaled1 = XW'(sum1_in) * XW'(hc2_pkg::RecipMul);
   assign scaled2 = XW'(sum2_in) * XW'(hc2_pkg::RecipMul);
   assign rem1_in = sum1_ff - SW'(quo1_ff) * SW'(hc2_pkg::Modulus);
   assign rem2_in = sum2_ff - SW'(quo2_ff) * SW'(hc2_pkg::Modulus);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod0_ff <= PW'(m0) * PW'(p1);
      prod1_ff <= PW'(m1) * PW'(p2);
      prod2_ff <= PW'(m2) * PW'(p1);
      prod3_ff <= PW'(m3) * PW'(p2);
      sum1_ff  <= sum1_in;
      sum2_ff  <= sum2_in;
      quo1_ff  <= scaled1[hc2_pkg::RecipShift +: QW];
      quo2_ff  <= scaled2[hc2_pkg::RecipShift +: QW];
      // hold the result until the next pass reaches the last stage
      if (vld_ff[1]) begin
         r1_ff <= rem1_in[VW-1:0];
         r2_ff <= rem2_in[VW-1:0];
      end
   end

   assign done = vld_ff[2];
   assign r1   = r1_ff;
   assign r2   = r2_ff;

endmodule

/* src/hc2_datapath.sv */
// Datapath of the Hill codec: key registers, held value, inverse key, result register.
module hc2_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [hc2_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hc2_pkg::CsrDataW-1:0] csr_wdata,
   input  logic [hc2_pkg::CharW-1:0]    req_char_code,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic [hc2_pkg::CharW-1:0]    rsp_out_letter,
   output logic [hc2_pkg::StatusW-1:0]  rsp_status,
   output logic                         rsp_last_out,
   input  hc2_pkg::hc2_cmd_type         cmd,
   output hc2_pkg::hc2_sts_type         sts
);

   localparam int unsigned VW = hc2_pkg::ValW;
   localparam int unsigned CW = hc2_pkg::CharW;

   logic [VW-1:0] key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic          mode_ff;
   logic [VW-1:0] cur_ff, held_ff, inv_ff;
   logic [VW-1:0] ik_ff [4];
   logic [VW-1:0] ka, kb, kc, kd;
   logic [VW-1:0] m0, m1, m2, m3, p1, p2, r1, r2;
   logic          dot_done;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] letter_ff, letter_in;
   logic [hc2_pkg::StatusW-1:0] status_ff, status_in;
   logic          last_ff;

   assign ka = hc2_pkg::mod26_key(key_a_ff);
   assign kb = hc2_pkg::mod26_key(key_b_ff);
   assign kc = hc2_pkg::mod26_key(key_c_ff);
   assign kd = hc2_pkg::mod26_key(key_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff <= VW'(1);
         key_b_ff <= '0;
         key_c_ff <= '0;
         key_d_ff <= VW'(1);
         mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hc2_pkg::RegKeyA: key_a_ff <= csr_wdata;
            hc2_pkg::RegKeyB: key_b_ff <= csr_wdata;
            hc2_pkg::RegKeyC: key_c_ff <= csr_wdata;
            hc2_pkg::RegKeyD: key_d_ff <= csr_wdata;
            hc2_pkg::RegMode: mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // operand select for the shared dot-product pipeline
   always_comb begin
      m0 = '0; m1 = '0; m2 = '0; m3 = '0; p1 = '0; p2 = '0;
      unique case (cmd.dot_op)
         hc2_pkg::OpDet: begin
            m0 = ka; m1 = kb; p1 = kd; p2 = hc2_pkg::neg26(kc);
         end
         hc2_pkg::OpInvLo: begin
            m0 = kd; m2 = hc2_pkg::neg26(kb); p1 = inv_ff;
         end
         hc2_pkg::OpInvHi: begin
            m0 = hc2_pkg::neg26(kc); m2 = ka; p1 = inv_ff;
         end
         hc2_pkg::OpPair: begin
            if (mode_ff) begin
               m0 = ik_ff[0]; m1 = ik_ff[1]; m2 = ik_ff[2]; m3 = ik_ff[3];
            end else begin
               m0 = ka; m1 = kb; m2 = kc; m3 = kd;
            end
            p1 = held_ff; p2 = cur_ff;
         end
         hc2_pkg::OpPad: begin
            m0 = ka; m1 = kb; m2 = kc; m3 = kd;
            p1 = cur_ff; p2 = hc2_pkg::PadValue;
         end
         default: ;
      endcase
   end

   hc2_dot u_dot (
      .clock (clock),
      .reset (reset),
      .go    (cmd.dot_go),
      .m0    (m0),
      .m1    (m1),
      .m2    (m2),
      .m3    (m3),
      .p1    (p1),
      .p2    (p2),
      .done  (dot_done),
      .r1    (r1),
      .r2    (r2)
   );

   // inv_ff at zero means no inverse
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= '0;
      end else if (cmd.wr_det) begin
         inv_ff <= hc2_pkg::inv26(r1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) cur_ff <= hc2_pkg::map_char(req_char_code, !mode_ff);
      if (cmd.hold) held_ff <= cur_ff;
      if (cmd.wr_ik_lo) begin
         ik_ff[0] <= r1;
         ik_ff[1] <= r2;
      end
      if (cmd.wr_ik_hi) begin
         ik_ff[2] <= r1;
         ik_ff[3] <= r2;
      end
   end

   always_comb begin
      letter_in = hc2_pkg::LetterBase;
      status_in = hc2_pkg::StatusOk;
      unique case (cmd.out_sel)
         hc2_pkg::SelRow1:   letter_in = hc2_pkg::LetterBase + CW'(r1);
         hc2_pkg::SelRow2:   letter_in = hc2_pkg::LetterBase + CW'(r2);
         hc2_pkg::SelErrKey: status_in = hc2_pkg::StatusKey;
         hc2_pkg::SelErrLen: status_in = hc2_pkg::StatusLen;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         letter_ff <= letter_in;
         status_ff <= status_in;
         last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_letter = letter_ff;
   assign rsp_status     = status_ff;
   assign rsp_last_out   = last_ff;

   assign sts.decrypt  = mode_ff;
   assign sts.inv_ok   = (inv_ff != '0);
   assign sts.dot_done = dot_done;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

/* src/hc2_checker.sv */
// Port-level checks of the Hill codec result channel, bound to the top level.
`include "hill_cipher_2x2_codec_core_assert.svh"

module hc2_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [hc2_pkg::CharW-1:0]   rsp_out_letter,
   input logic [hc2_pkg::StatusW-1:0] rsp_status,
   input logic                        rsp_last_out
);

   // a stalled transaction holds
   `HC2_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_letter) && $stable(rsp_status) && $stable(rsp_last_out))

   `HC2_ASSERT_IMP(a_letter_range, rsp_valid, rsp_out_letter >= hc2_pkg::LetterBase && rsp_out_letter <= (hc2_pkg::LetterBase + 7'd25))

   `HC2_ASSERT_IMP(a_err_letter, rsp_valid && rsp_status != hc2_pkg::StatusOk, rsp_out_letter == hc2_pkg::LetterBase)

   `HC2_ASSERT_IMP(a_status_code, rsp_valid, rsp_status == hc2_pkg::StatusOk || rsp_status == hc2_pkg::StatusKey || rsp_status == hc2_pkg::StatusLen)

   `HC2_ASSERT_IMP(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind hill_cipher_2x2_codec_core hc2_checker u_hc2_checker (.*);
